// ----- sv/cleaning_robot_navigation_fsm_core_macros.svh -----
`ifndef CLEANING_ROBOT_NAVIGATION_FSM_CORE_MACROS_SVH
`define CLEANING_ROBOT_NAVIGATION_FSM_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CRNAV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("navigation core check failed");

// next-cycle implication
`define CRNAV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("navigation core check failed");

`endif

// ----- sv/crnav_pkg.sv -----
`default_nettype none

package crnav_pkg;

  localparam int SPIN_W = 4;
  localparam logic [SPIN_W-1:0] SPIN_RESET = SPIN_W'(2);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_CLEAN  = 3'd1,
    MODE_AVOID  = 3'd2,
    MODE_PROBE  = 3'd3,
    MODE_ALIGN  = 3'd4,
    MODE_ESCAPE = 3'd5,
    MODE_SPIN   = 3'd6,
    MODE_LEAVE  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    PROBE_NONE    = 2'd0,
    PROBE_CHECK   = 2'd1,
    PROBE_BLOCKED = 2'd2,
    PROBE_OPEN    = 2'd3
  } probe_t;

  typedef enum logic [2:0] {
    MOVE_STOP  = 3'd0,
    MOVE_FWD   = 3'd1,
    MOVE_BACK  = 3'd2,
    MOVE_LEFT  = 3'd3,
    MOVE_RIGHT = 3'd4
  } motion_t;

  typedef enum logic [3:0] {
    REASON_IDLE          = 4'd0,
    REASON_SPIN          = 4'd1,
    REASON_LEAVE_STOP    = 4'd2,
    REASON_LEAVE_ESCAPE  = 4'd3,
    REASON_LEAVE_LEFT    = 4'd4,
    REASON_LEAVE_PROBE   = 4'd5,
    REASON_PROBE_BLOCKED = 4'd6,
    REASON_PROBE_OPEN    = 4'd7,
    REASON_ALIGN_STOP    = 4'd8,
    REASON_ALIGN_BACK    = 4'd9,
    REASON_ESCAPE_LEFT   = 4'd10,
    REASON_ESCAPE_PROBE  = 4'd11,
    REASON_CLEAR_FWD     = 4'd12,
    REASON_BLOCKED_LEFT  = 4'd13,
    REASON_BLOCKED_PROBE = 4'd14
  } reason_t;

  typedef struct packed {
    logic front;
    logic left;
    logic rear;
    logic dust;
  } sensors_t;

  typedef struct packed {
    mode_t             mode;
    probe_t            probe;
    logic              fwd;
    logic [SPIN_W-1:0] spin_left;
  } nav_state_t;

  typedef struct packed {
    motion_t motion;
    reason_t reason;
    mode_t   mode;
    probe_t  probe;
    logic    fwd;
  } nav_result_t;

endpackage

`default_nettype wire

// ----- sv/crnav_if.sv -----
`default_nettype none

interface crnav_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       front_obstacle;
  logic       left_obstacle;
  logic       rear_obstacle;
  logic       dust_detected;

  modport source (
    output valid, cmd, front_obstacle, left_obstacle, rear_obstacle, dust_detected,
    input  ready
  );
  modport sink (
    input  valid, cmd, front_obstacle, left_obstacle, rear_obstacle, dust_detected,
    output ready
  );
endinterface

interface crnav_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] motion;
  logic [3:0] reason_code;
  logic [2:0] mode;
  logic [1:0] probe_status;
  logic       heading_forward;

  modport source (
    output valid, motion, reason_code, mode, probe_status, heading_forward,
    input  ready
  );
  modport sink (
    input  valid, motion, reason_code, mode, probe_status, heading_forward,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/crnav_step.sv -----
`default_nettype none

module crnav_step import crnav_pkg::*; (
  input  wire cmd_t              cmd,
  input  wire sensors_t          sens,
  input  wire nav_state_t        state,
  input  wire logic [SPIN_W-1:0] spin_count,
  output nav_state_t             state_next,
  output nav_result_t            res,
  output logic                   has_result
);

  mode_t   m;
  motion_t mv;
  reason_t why;

  always_comb begin
    state_next = state;
    has_result = 1'b0;
    mv         = MOVE_STOP;
    why        = REASON_IDLE;
    m          = state.mode;
    unique case (cmd)
      CMD_START: begin
        state_next = '{mode: MODE_CLEAN, probe: PROBE_NONE, fwd: 1'b1, spin_left: '0};
      end
      CMD_STOP: begin
        state_next = '{mode: MODE_IDLE, probe: PROBE_NONE, fwd: 1'b1, spin_left: '0};
      end
      CMD_TICK: begin
        has_result = 1'b1;
        if (state.mode != MODE_IDLE) begin
          // spin finished: leave the dust cell this tick
          if (state.mode == MODE_SPIN && state.spin_left == '0) begin
            m = MODE_LEAVE;
          end
          state_next.mode = m;
          if (m == MODE_SPIN) begin
            state_next.spin_left = state.spin_left - SPIN_W'(1);
            mv  = MOVE_RIGHT;
            why = REASON_SPIN;
          end else if (m == MODE_LEAVE) begin
            if (state.fwd) begin
              state_next.mode  = MODE_ESCAPE;
              state_next.probe = PROBE_BLOCKED;
              mv  = sens.rear ? MOVE_STOP : MOVE_BACK;
              why = sens.rear ? REASON_LEAVE_STOP : REASON_LEAVE_ESCAPE;
            end else if (sens.front && !sens.left) begin
              state_next.mode  = MODE_AVOID;
              state_next.probe = PROBE_NONE;
              mv  = MOVE_LEFT;
              why = REASON_LEAVE_LEFT;
            end else if (sens.front) begin
              state_next.mode  = MODE_PROBE;
              state_next.probe = PROBE_CHECK;
              mv  = MOVE_RIGHT;
              why = REASON_LEAVE_PROBE;
            end else begin
              state_next.mode  = MODE_CLEAN;
              state_next.probe = PROBE_NONE;
              mv  = MOVE_FWD;
              why = REASON_LEAVE_ESCAPE;
            end
          end else if (sens.dust) begin
            state_next.mode      = MODE_SPIN;
            state_next.spin_left = (spin_count == '0) ? '0 : spin_count - SPIN_W'(1);
            mv  = MOVE_RIGHT;
            why = REASON_SPIN;
          end else if (m == MODE_PROBE) begin
            if (sens.front) begin
              state_next.mode  = MODE_ALIGN;
              state_next.probe = PROBE_BLOCKED;
              mv  = MOVE_LEFT;
              why = REASON_PROBE_BLOCKED;
            end else begin
              state_next.mode  = MODE_CLEAN;
              state_next.probe = PROBE_OPEN;
              state_next.fwd   = 1'b1;
              mv  = MOVE_FWD;
              why = REASON_PROBE_OPEN;
            end
          end else if (m == MODE_ALIGN) begin
            state_next.mode  = MODE_ESCAPE;
            state_next.probe = PROBE_BLOCKED;
            state_next.fwd   = 1'b0;
            mv  = sens.rear ? MOVE_STOP : MOVE_BACK;
            why = sens.rear ? REASON_ALIGN_STOP : REASON_ALIGN_BACK;
          end else if (m == MODE_ESCAPE) begin
            if (!sens.left) begin
              state_next.mode  = MODE_AVOID;
              state_next.probe = PROBE_NONE;
              mv  = MOVE_LEFT;
              why = REASON_ESCAPE_LEFT;
            end else begin
              state_next.mode  = MODE_PROBE;
              state_next.probe = PROBE_CHECK;
              mv  = MOVE_RIGHT;
              why = REASON_ESCAPE_PROBE;
            end
          end else if (!sens.front) begin
            state_next.mode  = MODE_CLEAN;
            state_next.probe = PROBE_NONE;
            state_next.fwd   = 1'b1;
            mv  = MOVE_FWD;
            why = REASON_CLEAR_FWD;
          end else if (!sens.left) begin
            state_next.mode  = MODE_AVOID;
            state_next.probe = PROBE_NONE;
            mv  = MOVE_LEFT;
            why = REASON_BLOCKED_LEFT;
          end else begin
            state_next.mode  = MODE_PROBE;
            state_next.probe = PROBE_CHECK;
            mv  = MOVE_RIGHT;
            why = REASON_BLOCKED_PROBE;
          end
        end
      end
      default: begin
        // unknown command word: ignored
        state_next = state;
      end
    endcase
    res = '{motion: mv, reason: why, mode: state_next.mode,
            probe: state_next.probe, fwd: state_next.fwd};
  end

endmodule

`default_nettype wire

// ----- sv/cleaning_robot_navigation_fsm_core.sv -----
// Reactive navigation controller for a cleaning robot.
// in_ch carries one command word: a sensor tick (front, left, rear obstacle
// and dust flags), start or stop. out_ch carries one result word per tick:
// motion, reason code, mode, probe status and heading flag after the tick.
// Start and stop change state only; they and unknown commands give no result.
// cfg_we / cfg_data write the spin tick count (ticks of right turning after
// dust); write it only while no command is in flight.
// A word accepted from in_ch is registered in the input register, decided there,
// and its result is registered in the result register before it shows on out_ch.
// Throughput: one word per cycle while out_ch does not stall; the mode
// update is a single short decision between the input and result registers.
// When the receiver stalls, the result register holds its word; the input
// register still takes a non-tick command, and a further tick waits there,
// so in_ch.ready drops only with both registers full.
// Reset (rst, synchronous): mode idle, probe none, heading forward,
// spin counter zero, spin tick count 2, both registers empty.
`default_nettype none

module cleaning_robot_navigation_fsm_core import crnav_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire logic [SPIN_W-1:0] cfg_data,
  crnav_in_if.sink               in_ch,
  crnav_out_if.source            out_ch
);

  `include "cleaning_robot_navigation_fsm_core_macros.svh"

  logic [SPIN_W-1:0] spin_count_q;
  logic              s1_valid;
  cmd_t              s1_cmd;
  sensors_t          s1_sens;
  nav_state_t        state;
  nav_state_t        state_next;
  nav_result_t       res;
  nav_result_t       out_res;
  logic              has_result;
  logic              out_valid;
  logic              advance;

  // input word leaves stage one if it gives no result or its result can go out
  assign advance     = s1_valid && (!has_result || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  crnav_step u_step (
    .cmd        (s1_cmd),
    .sens       (s1_sens),
    .state      (state),
    .spin_count (spin_count_q),
    .state_next (state_next),
    .res        (res),
    .has_result (has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_count_q <= SPIN_RESET;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      state        <= '{mode: MODE_IDLE, probe: PROBE_NONE, fwd: 1'b1, spin_left: '0};
    end else begin
      if (cfg_we) begin
        spin_count_q <= cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd  <= cmd_t'(in_ch.cmd);
      s1_sens <= '{front: in_ch.front_obstacle, left: in_ch.left_obstacle,
                   rear: in_ch.rear_obstacle, dust: in_ch.dust_detected};
    end
    if (advance && has_result) begin
      out_res <= res;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.motion          = out_res.motion;
  assign out_ch.reason_code     = out_res.reason;
  assign out_ch.mode            = out_res.mode;
  assign out_ch.probe_status    = out_res.probe;
  assign out_ch.heading_forward = out_res.fwd;

  `CRNAV_ASSERT_NOW(a_no_leave_shown, out_valid, out_res.mode != MODE_LEAVE)
  `CRNAV_ASSERT_NOW(a_idle_is_home, state.mode == MODE_IDLE,
                    state.probe == PROBE_NONE && state.fwd && state.spin_left == '0)
  `CRNAV_ASSERT_NEXT(a_tick_gives_word, advance && s1_cmd == CMD_TICK, out_valid)
  `CRNAV_ASSERT_NEXT(a_cmd_gives_none, advance && s1_cmd != CMD_TICK,
                     out_valid == $past(out_valid && !out_ch.ready))

endmodule

`default_nettype wire
